[rtl/ultrasonic_echo_ranger_top_macros.svh]
// Assertion macros shared by the ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define UER_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define UER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/uer_pkg.sv]
// Types and constants for the ultrasonic echo ranger.
package uer_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETUP,
      PH_PULSE,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ECHO = 2'd1;
   localparam logic [1:0] ST_OVER    = 2'd2;

   localparam logic [13:0] WIDTH_MAX = 14'h3FFF;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TICKS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE      = 3'd5;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_word_type;

   typedef struct packed {
      logic        trigger_level;
      logic        done_res;
      logic [15:0] distance;
      logic [1:0]  status;
      logic        busy_res;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  setup_low_ticks;
      logic [7:0]  pulse_high_ticks;
      logic [15:0] echo_wait_limit;
      logic [13:0] echo_max_ticks;
      logic [7:0]  max_range_cm;
      logic [15:0] cm_per_tick_scale;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] tick_count;
      logic [13:0] echo_width;
   } state_type;

endpackage

[rtl/uer_step.sv]
// One tick of the ranging sequencer: next state and the result word.
module uer_step
   import uer_pkg::*;
(
   input  cfg_type      cfg,
   input  state_type    cur,
   input  req_word_type word,
   output state_type    nxt,
   output rsp_word_type rsp
);

   logic [15:0] cap;
   logic [29:0] prod;
   logic [30:0] rounded;
   logic [22:0] dist_full;
   logic [15:0] dist_ok;
   logic        done;
   logic [15:0] dist_sel;
   logic [1:0]  stat;
   logic [15:0] tick_inc;

   assign cap       = {cfg.max_range_cm, 8'h00};
   assign prod      = 30'(cur.echo_width) * 30'(cfg.cm_per_tick_scale);
   assign rounded   = 31'(prod) + 31'd128;
   assign dist_full = rounded[30:8];
   assign dist_ok   = (dist_full > 23'(cap)) ? cap : dist_full[15:0];
   assign tick_inc  = cur.tick_count + 16'd1;

   always_comb begin
      nxt      = cur;
      done     = 1'b0;
      dist_sel = '0;
      stat     = ST_OK;
      unique case (cur.phase)
         PH_IDLE: begin
            if (word.start_req) begin
               nxt.phase      = (cfg.setup_low_ticks == 8'd0) ? PH_PULSE : PH_SETUP;
               nxt.tick_count = 16'd1;
               nxt.echo_width = '0;
            end
         end
         PH_SETUP: begin
            if (cur.tick_count >= 16'(cfg.setup_low_ticks)) begin
               nxt.phase      = PH_PULSE;
               nxt.tick_count = 16'd1;
            end else begin
               nxt.tick_count = tick_inc;
            end
         end
         PH_PULSE: begin
            // a pulse length of zero behaves the same as a length of one
            if (cur.tick_count >= 16'(cfg.pulse_high_ticks)) begin
               nxt.phase      = PH_WAIT;
               nxt.tick_count = '0;
            end else begin
               nxt.tick_count = tick_inc;
            end
         end
         PH_WAIT: begin
            if (word.echo_level) begin
               nxt.phase      = PH_MEAS;
               nxt.echo_width = 14'd1;
            end else if (cur.tick_count >= cfg.echo_wait_limit) begin
               done      = 1'b1;
               stat      = ST_NO_ECHO;
               nxt.phase = PH_IDLE;
            end else begin
               nxt.tick_count = tick_inc;
            end
         end
         PH_MEAS: begin
            if (word.echo_level) begin
               if (cur.echo_width > cfg.echo_max_ticks || cur.echo_width == WIDTH_MAX) begin
                  done      = 1'b1;
                  stat      = ST_OVER;
                  dist_sel  = cap;
                  nxt.phase = PH_IDLE;
               end else begin
                  nxt.echo_width = cur.echo_width + 14'd1;
               end
            end else begin
               done      = 1'b1;
               stat      = ST_OK;
               dist_sel  = dist_ok;
               nxt.phase = PH_IDLE;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.trigger_level = (nxt.phase == PH_PULSE);
      rsp.done_res      = done;
      rsp.distance      = dist_sel;
      rsp.status        = stat;
      rsp.busy_res      = (nxt.phase != PH_IDLE);
   end

endmodule

[rtl/ultrasonic_echo_ranger_top.sv]
// Ultrasonic echo ranger top level: input register, sequencer step, result register.
// A word accepted into the input register is stepped into the result register.
// Throughput: one word per cycle unless rsp_stall; the limit is the sequencer step
// with its 14x16 width-by-scale multiply between the input and result registers.
// Reset (synchronous, active high) returns to idle, empties both registers and
// loads the configuration defaults.
module ultrasonic_echo_ranger_top
   import uer_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   state_type    state_ff, state_in;
   rsp_word_type step_rsp;
   cfg_type      cfg_ff, cfg_in;
   logic         advance;
   logic         accept;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   uer_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .word (s1_word_ff),
      .nxt  (state_in),
      .rsp  (step_rsp)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SETUP_LOW:  cfg_in.setup_low_ticks   = csr_data[7:0];
            CSR_PULSE_HIGH: cfg_in.pulse_high_ticks  = csr_data[7:0];
            CSR_WAIT_LIMIT: cfg_in.echo_wait_limit   = csr_data;
            CSR_MAX_TICKS:  cfg_in.echo_max_ticks    = csr_data[13:0];
            CSR_MAX_RANGE:  cfg_in.max_range_cm      = csr_data[7:0];
            CSR_SCALE:      cfg_in.cm_per_tick_scale = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.phase          <= PH_IDLE;
         state_ff.tick_count     <= '0;
         state_ff.echo_width     <= '0;
         cfg_ff.setup_low_ticks   <= 8'd2;
         cfg_ff.pulse_high_ticks  <= 8'd10;
         cfg_ff.echo_wait_limit   <= 16'd50000;
         cfg_ff.echo_max_ticks    <= 14'd10000;
         cfg_ff.max_range_cm      <= 8'd200;
         cfg_ff.cm_per_tick_scale <= 16'd1126;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

endmodule

[rtl/uer_checker.sv]
// Port-level checker for the ranger, bound to the top level.
`include "ultrasonic_echo_ranger_top_macros.svh"

module uer_checker
   import uer_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input req_word_type           req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_word_type           rsp_word,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_data
);

   // trigger is only driven inside a measurement
   `UER_ASSERT(a_trig_busy, clock, reset, rsp_valid && rsp_word.trigger_level |-> rsp_word.busy_res && !rsp_word.done_res, "trigger high outside a measurement")

   // a finishing word leaves the block idle
   `UER_ASSERT(a_done_idle, clock, reset, rsp_valid && rsp_word.done_res |-> !rsp_word.busy_res && rsp_word.status != 2'b11, "done word still busy or bad status")

   // results carry no distance or status unless done
   `UER_ASSERT(a_quiet_fields, clock, reset, rsp_valid && !rsp_word.done_res |-> rsp_word.distance == 16'd0 && rsp_word.status == ST_OK, "fields set on a word that is not done")

   // a stalled result word holds
   `UER_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result word changed")

   // nothing comes out right after reset
   `UER_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (.*);
